// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define GGSP_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("assertion failed");

`define GGSP_ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define GGSP_ASSERT_IMP(label, clk_s, rstn_s, ante, cons)

`define GGSP_ASSERT_NXT(label, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== hw/rtl/ggsp_pkg.sv =====
`timescale 1ns / 1ps

package ggsp_pkg;

	localparam int POS_W     = 6;
	localparam int MRG_W     = 3;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CRD_W     = 12;
	localparam int WIN_W     = 15;
	localparam int OFF_W     = 4;

	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [2:0] {
		MOVE_DONE  = 3'd0,
		MOVE_UP    = 3'd1,
		MOVE_DOWN  = 3'd2,
		MOVE_LEFT  = 3'd3,
		MOVE_RIGHT = 3'd4
	} move_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_VALID = 2'd0,
		REG_TARGET_ROW   = 2'd1,
		REG_TARGET_COL   = 2'd2,
		REG_MARGIN       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic wr_wr;
		logic scan;
		logic rec;
		logic rec_free;
		logic give_up;
	} ggsp_cmd_t;

	typedef struct packed {
		logic  clr_last;
		logic  done_now;
		logic  in_bounds;
		logic  scan_done;
		logic  scan_free;
		logic  lowers;
		logic  last_cand;
		move_t cand_move;
		logic  pick_any;
		move_t pick_move;
	} ggsp_sts_t;

endpackage

// ===== hw/rtl/ggsp_ifs.sv =====
`timescale 1ns / 1ps

interface ggsp_req_if;
	import ggsp_pkg::*;

	logic             valid;
	logic             ready;
	logic             req_type;
	logic [POS_W-1:0] row;
	logic [POS_W-1:0] col;
	logic             occupied;

	modport source (output valid, req_type, row, col, occupied, input ready);
	modport sink (input valid, req_type, row, col, occupied, output ready);
endinterface

interface ggsp_rsp_if;
	import ggsp_pkg::*;

	logic  valid;
	logic  ready;
	move_t move;

	modport source (output valid, move, input ready);
	modport sink (input valid, move, output ready);
endinterface

// ===== hw/rtl/greedy_grid_step_planner.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Greedy grid step planner. After reset the grid memory is cleared one row per cycle, so
// no item is taken until the last row is cleared (configuration writes still land). A
// write item reads, modifies and writes back one grid row. A query answered as done at
// once skips the candidate scan; otherwise each of the four candidate moves that lies
// in bounds has its footprint read one grid row per cycle through the single read port
// of the grid memory. The scan of a candidate stops early on the first occupied row, and
// the query ends at the first candidate that is free and closer to the target. One item
// is in work at a time; a finished move waits in the output register while the next item
// is accepted.
module greedy_grid_step_planner #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ggsp_req_if.sink                           req,
	ggsp_rsp_if.source                         rsp,
	input  logic                               cfg_we,
	input  logic [ggsp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [ggsp_pkg::CFG_W-1:0]         cfg_wdata
);
	import ggsp_pkg::*;

	ggsp_cmd_t cmd;
	ggsp_sts_t sts;

	ggsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_move  (rsp.move),
		.cmd       (cmd),
		.sts       (sts)
	);

	ggsp_dp #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req_row   (req.row),
		.req_col   (req.col),
		.req_occ   (req.occupied)
	);

	`GGSP_ASSERT_IMP(a_scan_in_bounds, clk, arst_n, cmd.scan, sts.in_bounds)
	`GGSP_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, cmd.clr, !req.ready)
	`GGSP_ASSERT_NXT(a_busy_after_accept, clk, arst_n, cmd.load, !req.ready)

endmodule

// ===== hw/rtl/ggsp_ram.sv =====
`timescale 1ns / 1ps

module ggsp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/ggsp_dp.sv =====
`timescale 1ns / 1ps

module ggsp_dp #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ggsp_pkg::ggsp_cmd_t                 cmd,
	output ggsp_pkg::ggsp_sts_t                 sts,
	input  logic                                cfg_we,
	input  logic [ggsp_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [ggsp_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic [ggsp_pkg::POS_W-1:0]          req_row,
	input  logic [ggsp_pkg::POS_W-1:0]          req_col,
	input  logic                                req_occ
);
	import ggsp_pkg::*;

	localparam int RAW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CAW   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int DIF_W = POS_W + 1;
	localparam logic signed [CRD_W-1:0] ROWS_C = CRD_W'(GRID_ROWS);
	localparam logic signed [CRD_W-1:0] COLS_C = CRD_W'(GRID_COLS);

	typedef move_t [3:0] cand_vec_t;

	function automatic cand_vec_t build_cands(input logic signed [DIF_W-1:0] dr,
			input logic signed [DIF_W-1:0] dc);
		move_t            lst [6];
		logic [5:0]       lv;
		logic [4:0]       seen;
		cand_vec_t        res;
		logic [2:0]       n;
		logic [DIF_W-1:0] adr;
		logic [DIF_W-1:0] adc;
		move_t            col_mv;
		move_t            row_mv;
		adr = dr[DIF_W-1] ? DIF_W'(-dr) : DIF_W'(dr);
		adc = dc[DIF_W-1] ? DIF_W'(-dc) : DIF_W'(dc);
		col_mv = (dc > 0) ? MOVE_RIGHT : MOVE_LEFT;
		row_mv = (dr > 0) ? MOVE_DOWN : MOVE_UP;
		if (adc >= adr) begin
			lst[0] = col_mv;
			lv[0]  = (dc != 0);
			lst[1] = row_mv;
			lv[1]  = (dr != 0);
		end else begin
			lst[0] = row_mv;
			lv[0]  = (dr != 0);
			lst[1] = col_mv;
			lv[1]  = (dc != 0);
		end
		lst[2] = MOVE_UP;
		lst[3] = MOVE_DOWN;
		lst[4] = MOVE_LEFT;
		lst[5] = MOVE_RIGHT;
		lv[5:2] = '1;
		for (int k = 0; k < 4; k++) begin
			res[k] = MOVE_DONE;
		end
		seen = '0;
		n = '0;
		for (int i = 0; i < 6; i++) begin
			if (lv[i] && !seen[lst[i]] && (n < 3'd4)) begin
				res[n[1:0]] = lst[i];
				seen[lst[i]] = 1'b1;
				n = n + 3'd1;
			end
		end
		return res;
	endfunction

	// config and query state
	logic             tvalid_q;
	logic [POS_W-1:0] trow_q;
	logic [POS_W-1:0] tcol_q;
	logic [MRG_W-1:0] margin_q;
	logic             gave_up_q;
	logic [POS_W-1:0] qrow_q;
	logic [POS_W-1:0] qcol_q;
	logic             wocc_q;
	logic [RAW-1:0]   clr_q;
	logic [1:0]       idx_q;
	logic [3:0]       free_q;
	logic [OFF_W-1:0] iss_q;
	logic             pend_s1;
	logic [OFF_W-1:0] toff_s1;

	logic signed [DIF_W-1:0] dr;
	logic signed [DIF_W-1:0] dc;
	cand_vec_t               cands;
	move_t                   cand_cur;
	logic signed [CRD_W-1:0] nr;
	logic signed [CRD_W-1:0] nc;
	logic signed [CRD_W-1:0] m;
	logic signed [CRD_W-1:0] rs;
	logic signed [CRD_W-1:0] re;
	logic signed [CRD_W-1:0] cs;
	logic signed [CRD_W-1:0] ce;
	logic signed [CRD_W-1:0] row_iss;
	logic [CRD_W-1:0]        req_ext;
	logic [CRD_W-1:0]        qrow_ext;
	logic [CRD_W-1:0]        qcol_ext;
	logic [OFF_W-1:0]        span;
	logic [OFF_W:0]          wid;
	logic                    in_bounds;
	logic                    hit;
	logic                    wr_in_range;
	logic [GRID_COLS+WIN_W-1:0] ext;
	logic [WIN_W-1:0]        win;
	logic [WIN_W-1:0]        mask;

	logic                 ram_we;
	logic [RAW-1:0]       ram_waddr;
	logic [GRID_COLS-1:0] ram_wdata;
	logic [RAW-1:0]       ram_raddr;
	logic [GRID_COLS-1:0] ram_rdata;
	logic [GRID_COLS-1:0] row_new;

	ggsp_ram #(
		.WIDTH (GRID_COLS),
		.DEPTH (GRID_ROWS)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign dr = signed'({1'b0, trow_q}) - signed'({1'b0, qrow_q});
	assign dc = signed'({1'b0, tcol_q}) - signed'({1'b0, qcol_q});
	assign cands = build_cands(dr, dc);
	assign cand_cur = cands[idx_q];

	assign req_ext  = CRD_W'(req_row);
	assign qrow_ext = CRD_W'(qrow_q);
	assign qcol_ext = CRD_W'(qcol_q);
	assign m = signed'(CRD_W'(margin_q));

	always_comb begin
		nr = signed'(qrow_ext);
		nc = signed'(qcol_ext);
		unique case (cand_cur)
			MOVE_UP:    nr = signed'(qrow_ext) - CRD_W'(1);
			MOVE_DOWN:  nr = signed'(qrow_ext) + CRD_W'(1);
			MOVE_LEFT:  nc = signed'(qcol_ext) - CRD_W'(1);
			MOVE_RIGHT: nc = signed'(qcol_ext) + CRD_W'(1);
			default: begin
			end
		endcase
	end

	// footprint bounds of the current candidate
	assign rs = nr - m;
	assign re = nr + m;
	assign cs = nc - m;
	assign ce = nc + m;
	assign in_bounds = (rs >= 0) && (re < ROWS_C) && (cs >= 0) && (ce < COLS_C);

	assign span = OFF_W'({margin_q, 1'b0});
	assign wid  = {1'b0, span} + (OFF_W+1)'(1);
	assign row_iss = rs + signed'(CRD_W'(iss_q));

	// window test on the row read last cycle
	assign ext  = {{WIN_W{1'b0}}, ram_rdata} >> cs[CAW-1:0];
	assign win  = ext[WIN_W-1:0];
	assign mask = ~({WIN_W{1'b1}} << wid);
	assign hit  = |(win & mask);

	assign wr_in_range = (qrow_ext < CRD_W'(GRID_ROWS)) && (qcol_ext < CRD_W'(GRID_COLS));

	always_comb begin
		row_new = ram_rdata;
		row_new[qcol_ext[CAW-1:0]] = wocc_q;
	end

	assign ram_raddr = cmd.scan ? row_iss[RAW-1:0] : req_ext[RAW-1:0];
	assign ram_we    = cmd.clr || (cmd.wr_wr && wr_in_range);
	assign ram_waddr = cmd.clr ? clr_q : qrow_ext[RAW-1:0];
	assign ram_wdata = cmd.clr ? '0 : row_new;

	always_comb begin
		sts.clr_last  = (clr_q == RAW'(GRID_ROWS - 1));
		sts.done_now  = !tvalid_q || gave_up_q || ((qrow_q == trow_q) && (qcol_q == tcol_q));
		sts.in_bounds = in_bounds;
		sts.scan_done = pend_s1 && (hit || (toff_s1 == span));
		sts.scan_free = !hit;
		unique case (cand_cur)
			MOVE_UP:    sts.lowers = (dr < 0);
			MOVE_DOWN:  sts.lowers = (dr > 0);
			MOVE_LEFT:  sts.lowers = (dc < 0);
			MOVE_RIGHT: sts.lowers = (dc > 0);
			default:    sts.lowers = 1'b0;
		endcase
		sts.last_cand = &idx_q;
		sts.cand_move = cand_cur;
		sts.pick_any  = |free_q;
		sts.pick_move = MOVE_DONE;
		for (int k = 3; k >= 0; k--) begin
			if (free_q[k]) begin
				sts.pick_move = cands[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q  <= 1'b0;
			trow_q    <= '0;
			tcol_q    <= '0;
			margin_q  <= '0;
			gave_up_q <= 1'b0;
			clr_q     <= '0;
			idx_q     <= '0;
			free_q    <= '0;
			iss_q     <= '0;
			pend_s1   <= 1'b0;
			toff_s1   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_idx))
					REG_TARGET_VALID: begin
						tvalid_q  <= cfg_wdata[0];
						gave_up_q <= 1'b0;
					end
					REG_TARGET_ROW: begin
						trow_q    <= cfg_wdata[POS_W-1:0];
						gave_up_q <= 1'b0;
					end
					REG_TARGET_COL: begin
						tcol_q    <= cfg_wdata[POS_W-1:0];
						gave_up_q <= 1'b0;
					end
					REG_MARGIN: begin
						margin_q <= cfg_wdata[MRG_W-1:0];
					end
				endcase
			end else if (cmd.give_up) begin
				gave_up_q <= 1'b1;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + RAW'(1);
			end
			if (cmd.load) begin
				idx_q  <= '0;
				free_q <= '0;
			end else if (cmd.rec) begin
				free_q[idx_q] <= cmd.rec_free;
				idx_q <= idx_q + 2'd1;
			end
			if (cmd.scan) begin
				iss_q   <= iss_q + OFF_W'(1);
				pend_s1 <= (iss_q <= span);
				toff_s1 <= iss_q;
			end else begin
				iss_q   <= '0;
				pend_s1 <= 1'b0;
				toff_s1 <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qrow_q <= req_row;
			qcol_q <= req_col;
			wocc_q <= req_occ;
		end
	end

endmodule

// ===== hw/rtl/ggsp_ctrl.sv =====
`timescale 1ns / 1ps

module ggsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_type,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ggsp_pkg::move_t     rsp_move,
	output ggsp_pkg::ggsp_cmd_t cmd,
	input  ggsp_pkg::ggsp_sts_t sts
);
	import ggsp_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_WR,
		ST_Q_EVAL,
		ST_BOUND,
		ST_SCAN,
		ST_PICK,
		ST_FINISH
	} state_t;

	state_t state_q;
	move_t  mv_q;
	logic   out_valid_q;
	move_t  out_move_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp_move  = out_move_q;

	always_comb begin
		cmd          = '0;
		cmd.clr      = (state_q == ST_CLEAR);
		cmd.load     = (state_q == ST_IDLE) && req_valid;
		cmd.wr_wr    = (state_q == ST_WR_WR);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.rec      = ((state_q == ST_BOUND) && !sts.in_bounds)
			|| ((state_q == ST_SCAN) && sts.scan_done);
		cmd.rec_free = (state_q == ST_SCAN) && sts.scan_free;
		cmd.give_up  = (state_q == ST_PICK) && !sts.pick_any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mv_q        <= MOVE_DONE;
			out_valid_q <= 1'b0;
			out_move_q  <= MOVE_DONE;
		end else begin
			if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= (req_type == REQ_QUERY) ? ST_Q_EVAL : ST_WR_WR;
					end
				end
				ST_WR_WR: begin
					state_q <= ST_IDLE;
				end
				ST_Q_EVAL: begin
					if (sts.done_now) begin
						mv_q    <= MOVE_DONE;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_BOUND;
					end
				end
				ST_BOUND: begin
					if (sts.in_bounds) begin
						state_q <= ST_SCAN;
					end else if (sts.last_cand) begin
						state_q <= ST_PICK;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						if (sts.scan_free && sts.lowers) begin
							mv_q    <= sts.cand_move;
							state_q <= ST_FINISH;
						end else if (sts.last_cand) begin
							state_q <= ST_PICK;
						end else begin
							state_q <= ST_BOUND;
						end
					end
				end
				ST_PICK: begin
					mv_q    <= sts.pick_move;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || rsp_ready) begin
						out_valid_q <= 1'b1;
						out_move_q  <= mv_q;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule
